// ----- hdl/lkmc_pkg.sv -----
package lkmc_pkg;

    localparam int SampleW = 10;
    localparam int TimeW   = 32;
    localparam int HoldW   = 16;
    localparam int IndexW  = 3;
    localparam int DataW   = 16;

    typedef enum logic [1:0] {
        KEY_IDLE  = 2'd0,
        KEY_PRESS = 2'd1,
        KEY_DN    = 2'd2,
        KEY_UP    = 2'd3
    } key_t;

    typedef enum logic [1:0] {
        MODE_STOPPED  = 2'd0,
        MODE_SENSOR   = 2'd1,
        MODE_CLIMATE  = 2'd2,
        MODE_POSITION = 2'd3
    } mode_t;

    localparam logic [IndexW-1:0] REG_UP_LEVEL    = 3'd0;
    localparam logic [IndexW-1:0] REG_DOWN_LEVEL  = 3'd1;
    localparam logic [IndexW-1:0] REG_PRESS_LEVEL = 3'd2;
    localparam logic [IndexW-1:0] REG_WINDOW_HALF = 3'd3;
    localparam logic [IndexW-1:0] REG_HOLD_TIME   = 3'd4;

    localparam logic [SampleW-1:0] UP_LEVEL_RST    = 10'd1021;
    localparam logic [SampleW-1:0] DOWN_LEVEL_RST  = 10'd651;
    localparam logic [SampleW-1:0] PRESS_LEVEL_RST = 10'd729;
    localparam logic [SampleW-1:0] WINDOW_HALF_RST = 10'd50;
    localparam logic [HoldW-1:0]   HOLD_TIME_RST   = 16'd1000;

    typedef struct packed {
        logic [SampleW-1:0] up_level;
        logic [SampleW-1:0] down_level;
        logic [SampleW-1:0] press_level;
        logic [SampleW-1:0] window_half;
        logic [HoldW-1:0]   hold_time_ms;
    } cfg_t;

    typedef struct packed {
        mode_t mode;
        key_t  key_code;
        logic  clear_display;
        logic  calibrate;
    } result_t;

endpackage

// ----- hdl/lkmc_key_decode.sv -----
module lkmc_key_decode
    import lkmc_pkg::*;
(
    input  logic [SampleW-1:0] sample,
    input  cfg_t               cfg,
    output key_t               key
);

    // level-half < s < level+half, rewritten as s < level+half and s+half > level
    // so every term stays non-negative
    function automatic logic hit(logic [SampleW-1:0] s, logic [SampleW-1:0] level,
                                 logic [SampleW-1:0] half);
        logic [SampleW:0] hi;
        logic [SampleW:0] sh;
        hi = {1'b0, level} + {1'b0, half};
        sh = {1'b0, s} + {1'b0, half};
        return ({1'b0, s} < hi) && (sh > {1'b0, level});
    endfunction

    always_comb
    begin
        if (hit(sample, cfg.press_level, cfg.window_half))
            key = KEY_PRESS;
        else if (hit(sample, cfg.down_level, cfg.window_half))
            key = KEY_DN;
        else if (hit(sample, cfg.up_level, cfg.window_half))
            key = KEY_UP;
        else
            key = KEY_IDLE;
    end

endmodule

// ----- hdl/lkmc_mode_core.sv -----
module lkmc_mode_core
    import lkmc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  key_t             key,
    input  logic [TimeW-1:0] now_ms,
    input  logic [HoldW-1:0] hold_time_ms,
    output mode_t            mode_next,
    output logic             clr,
    output logic             cal
);

    mode_t            mode_reg;
    key_t             prev_key_reg, prev_key_next;
    logic [TimeW-1:0] elapsed_reg, elapsed_next;
    logic [TimeW-1:0] begin_reg, begin_next;

    logic held;
    logic hold_fire;
    mode_t rot_up, rot_down;

    assign held      = (prev_key_reg != KEY_IDLE) && (key != KEY_IDLE) && (key != KEY_PRESS);
    assign hold_fire = elapsed_reg > {{(TimeW-HoldW){1'b0}}, hold_time_ms};

    always_comb
    begin
        case (mode_reg)
            MODE_SENSOR:
            begin
                rot_up   = MODE_POSITION;
                rot_down = MODE_CLIMATE;
            end
            MODE_CLIMATE:
            begin
                rot_up   = MODE_SENSOR;
                rot_down = MODE_POSITION;
            end
            MODE_POSITION:
            begin
                rot_up   = MODE_CLIMATE;
                rot_down = MODE_SENSOR;
            end
            default:
            begin
                rot_up   = mode_reg;
                rot_down = mode_reg;
            end
        endcase
    end

    // next state
    always_comb
    begin
        mode_next     = mode_reg;
        prev_key_next = prev_key_reg;
        elapsed_next  = elapsed_reg;
        begin_next    = begin_reg;
        if (!held)
        begin
            prev_key_next = key;
            if (key == KEY_PRESS)
            begin
                if (hold_fire)
                begin
                    mode_next    = (mode_reg == MODE_STOPPED) ? MODE_SENSOR : MODE_STOPPED;
                    elapsed_next = '0;
                end
                else if (elapsed_reg == '0)
                begin
                    begin_next   = now_ms;
                    elapsed_next = {{(TimeW-1){1'b0}}, 1'b1};
                end
                else
                begin
                    elapsed_next = now_ms - begin_reg;
                end
            end
            else if (mode_reg != MODE_STOPPED && key == KEY_UP)
                mode_next = rot_up;
            else if (mode_reg != MODE_STOPPED && key == KEY_DN)
                mode_next = rot_down;
            else
                elapsed_next = '0;
        end
    end

    // pulses
    always_comb
    begin
        clr = 1'b0;
        cal = 1'b0;
        if (!held)
        begin
            if (key == KEY_PRESS)
            begin
                if (mode_reg == MODE_SENSOR && elapsed_reg == {{(TimeW-1){1'b0}}, 1'b1})
                    cal = 1'b1;
                if (hold_fire)
                begin
                    clr = 1'b1;
                    if (mode_reg == MODE_STOPPED)
                        cal = 1'b1;
                end
            end
            else if (mode_reg != MODE_STOPPED && (key == KEY_UP || key == KEY_DN))
                clr = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_STOPPED;
            prev_key_reg <= KEY_IDLE;
            elapsed_reg  <= '0;
            begin_reg    <= '0;
        end
        else if (step)
        begin
            mode_reg     <= mode_next;
            prev_key_reg <= prev_key_next;
            elapsed_reg  <= elapsed_next;
            begin_reg    <= begin_next;
        end
    end

    a_held_keeps_mode: assert property (@(posedge clk) disable iff (!rst_n)
        step && held |=> $stable(mode_reg))
        else $error("held repeat changed mode");

    a_fire_clears_timer: assert property (@(posedge clk) disable iff (!rst_n)
        step && !held && key == KEY_PRESS && hold_fire |=> elapsed_reg == '0)
        else $error("hold fire did not clear timer");

    // calibrate comes from a press only: first timed press in sensor, or a start
    a_cal_needs_press: assert property (@(posedge clk) disable iff (!rst_n)
        step && cal |-> key == KEY_PRESS)
        else $error("calibrate without press");

endmodule

// ----- hdl/ladder_key_mode_controller.sv -----
// Ladder key mode controller.
// Input channel (in_valid/in_stall): one beat carries a 10-bit ladder switch
// sample and a 32-bit millisecond timestamp. Output channel (out_valid/out_stall):
// one beat per input beat with mode, decoded key, clear_display and calibrate.
// Config channel (cfg_valid/cfg_ready): cfg_index selects up_level, down_level,
// press_level, window_half or hold_time_ms; other indexes are dropped.
// cfg_ready is always high; write only while no beat is in flight.
// Path: a beat is captured in the input register, then decoded and stepped
// through the mode core into the result register. Throughput: one beat per
// cycle when not stalled; decode, window compares and the single timestamp subtraction sit between the two registers.
// Stall: when out_stall holds a full result register, the input register
// holds too and in_stall rises while it is occupied; nothing is dropped.
// Reset: mode stopped, no previous key, hold timer cleared, config registers
// at their defaults, both pipeline stages empty.
module ladder_key_mode_controller
    import lkmc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [SampleW-1:0] key_sample,
    input  logic [TimeW-1:0]   now_ms,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         mode,
    output logic [1:0]         key_code,
    output logic               clear_display,
    output logic               calibrate,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [IndexW-1:0]  cfg_index,
    input  logic [DataW-1:0]   cfg_data
);

    cfg_t cfg_reg;

    logic               s1_valid_reg, s1_valid_next;
    logic [SampleW-1:0] s1_sample_reg;
    logic [TimeW-1:0]   s1_now_reg;

    logic               out_valid_reg, out_valid_next;
    result_t            res_reg;

    logic  advance;
    logic  in_take;
    key_t  key;
    mode_t mode_nx;
    logic  clr, cal;

    assign cfg_ready = 1'b1;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.up_level     <= UP_LEVEL_RST;
            cfg_reg.down_level   <= DOWN_LEVEL_RST;
            cfg_reg.press_level  <= PRESS_LEVEL_RST;
            cfg_reg.window_half  <= WINDOW_HALF_RST;
            cfg_reg.hold_time_ms <= HOLD_TIME_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_UP_LEVEL:    cfg_reg.up_level     <= cfg_data[SampleW-1:0];
                REG_DOWN_LEVEL:  cfg_reg.down_level   <= cfg_data[SampleW-1:0];
                REG_PRESS_LEVEL: cfg_reg.press_level  <= cfg_data[SampleW-1:0];
                REG_WINDOW_HALF: cfg_reg.window_half  <= cfg_data[SampleW-1:0];
                REG_HOLD_TIME:   cfg_reg.hold_time_ms <= cfg_data[HoldW-1:0];
                default: ;
            endcase
        end
    end

    // stage 1 moves on whenever the result register is empty or being taken
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        if (in_take)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
        out_valid_next = advance ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_sample_reg <= key_sample;
            s1_now_reg    <= now_ms;
        end
    end

    lkmc_key_decode u_decode (
        .sample (s1_sample_reg),
        .cfg    (cfg_reg),
        .key    (key)
    );

    lkmc_mode_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (s1_valid_reg && advance),
        .key          (key),
        .now_ms       (s1_now_reg),
        .hold_time_ms (cfg_reg.hold_time_ms),
        .mode_next    (mode_nx),
        .clr          (clr),
        .cal          (cal)
    );

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            res_reg.mode          <= mode_nx;
            res_reg.key_code      <= key;
            res_reg.clear_display <= clr;
            res_reg.calibrate     <= cal;
        end
    end

    assign out_valid     = out_valid_reg;
    assign mode          = res_reg.mode;
    assign key_code      = res_reg.key_code;
    assign clear_display = res_reg.clear_display;
    assign calibrate     = res_reg.calibrate;

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg && out_stall)
        else $error("input stalled with room in pipeline");

    a_result_follows_stage1: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && advance |=> out_valid_reg)
        else $error("stage 1 beat lost");

    a_held_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> out_valid_reg && $stable(res_reg))
        else $error("stalled result changed");

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
    import lkmc_pkg::*;

    // Cycles with no accepted beat on any channel before the run is declared hung.
    // The longest planned quiet stretch is the receiver hold-off below.
    localparam int QUIET_LIMIT   = 2000;
    // Wait after the last result has been taken, before config writes.
    localparam int RESULT_SLACK  = 4;
    localparam int HOLDOFF_LEN   = 60;
    localparam int IDLE_PCT      = 17;
    localparam int MAX_REPORTS   = 10;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [SampleW-1:0]  key_sample;
    logic [TimeW-1:0]    now_ms;
    logic                out_valid;
    logic                out_stall;
    logic [1:0]          mode;
    logic [1:0]          key_code;
    logic                clear_display;
    logic                calibrate;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [IndexW-1:0]   cfg_index;
    logic [DataW-1:0]    cfg_data;

    ladder_key_mode_controller dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .key_sample    (key_sample),
        .now_ms        (now_ms),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .mode          (mode),
        .key_code      (key_code),
        .clear_display (clear_display),
        .calibrate     (calibrate),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow of the controller: config registers plus the four state regs.
    // ------------------------------------------------------------------
    cfg_t               ladder_cfg;
    mode_t              cur_mode;
    key_t               last_key;
    logic [TimeW-1:0]   hold_elapsed;
    logic [TimeW-1:0]   hold_begin;

    result_t            pending_results[$];
    int                 error_count = 0;
    int                 items_sent = 0;
    logic [TimeW-1:0]   clock_ms;

    // Idle / stall knobs shared between the test tasks and the channel processes.
    int                 tx_idle_pct = IDLE_PCT;
    int                 rx_stall_pct = IDLE_PCT;
    int                 holdoff_cycles = 0;

    // Strict window, signed so a window can hang off either end of the ADC range.
    function automatic bit in_ladder_window(int s, logic [SampleW-1:0] level);
        int c;
        int h;
        c = level;
        h = ladder_cfg.window_half;
        return (s < c + h) && (s > c - h);
    endfunction

    // Priority: press, then down, then up.
    function automatic key_t decode_ladder(logic [SampleW-1:0] sample);
        int s;
        s = sample;
        if (in_ladder_window(s, ladder_cfg.press_level)) return KEY_PRESS;
        if (in_ladder_window(s, ladder_cfg.down_level))  return KEY_DN;
        if (in_ladder_window(s, ladder_cfg.up_level))    return KEY_UP;
        return KEY_IDLE;
    endfunction

    // Advances the shadow state by one beat and returns the result it should produce.
    function automatic result_t predict_mode_step(logic [SampleW-1:0] sample,
                                                  logic [TimeW-1:0] t);
        result_t r;
        key_t    k;
        mode_t   next_up;
        mode_t   next_down;
        k = decode_ladder(sample);
        r.key_code      = k;
        r.clear_display = 1'b0;
        r.calibrate     = 1'b0;
        // up/down while a key is still down: held repeat, nothing moves
        if (!(last_key != KEY_IDLE && k != KEY_IDLE && k != KEY_PRESS))
        begin
            last_key  = k;
            next_up   = cur_mode;
            next_down = cur_mode;
            case (cur_mode)
                MODE_SENSOR:
                begin
                    next_up   = MODE_POSITION;
                    next_down = MODE_CLIMATE;
                end
                MODE_CLIMATE:
                begin
                    next_up   = MODE_SENSOR;
                    next_down = MODE_POSITION;
                end
                MODE_POSITION:
                begin
                    next_up   = MODE_CLIMATE;
                    next_down = MODE_SENSOR;
                end
                default: ;
            endcase
            if (k == KEY_PRESS)
            begin
                // first timed press in sensor mode asks for a recalibration
                if (cur_mode == MODE_SENSOR && hold_elapsed == 1) r.calibrate = 1'b1;
                if (hold_elapsed > {16'b0, ladder_cfg.hold_time_ms})
                begin
                    r.clear_display = 1'b1;
                    if (cur_mode == MODE_STOPPED)
                    begin
                        r.calibrate = 1'b1;
                        cur_mode    = MODE_SENSOR;
                    end
                    else
                    begin
                        cur_mode = MODE_STOPPED;
                    end
                    hold_elapsed = '0;
                end
                else if (hold_elapsed == 0)
                begin
                    hold_begin   = t;
                    hold_elapsed = 1;
                end
                else
                begin
                    hold_elapsed = t - hold_begin;  // wraps mod 2^32
                end
            end
            else if (cur_mode != MODE_STOPPED && k == KEY_UP)
            begin
                cur_mode        = next_up;
                r.clear_display = 1'b1;
            end
            else if (cur_mode != MODE_STOPPED && k == KEY_DN)
            begin
                cur_mode        = next_down;
                r.clear_display = 1'b1;
            end
            else
            begin
                hold_elapsed = '0;
            end
        end
        r.mode = cur_mode;
        return r;
    endfunction

    // Sample aimed at the window of key k under the current config.
    function automatic logic [SampleW-1:0] sample_for(key_t k);
        int               c;
        int               lo;
        int               hi;
        logic [SampleW-1:0] s;
        case (k)
            KEY_PRESS: c = ladder_cfg.press_level;
            KEY_DN:    c = ladder_cfg.down_level;
            KEY_UP:    c = ladder_cfg.up_level;
            default:
            begin
                s = SampleW'($urandom_range(1023, 0));
                repeat (8)
                begin
                    if (decode_ladder(s) == KEY_IDLE) return s;
                    s = SampleW'($urandom_range(1023, 0));
                end
                return s;
            end
        endcase
        lo = c - int'(ladder_cfg.window_half) + 1;
        hi = c + int'(ladder_cfg.window_half) - 1;
        if (lo < 0) lo = 0;
        if (hi > 1023) hi = 1023;
        if (lo > hi) return SampleW'($urandom_range(1023, 0));
        return SampleW'($urandom_range(hi, lo));
    endfunction

    task automatic report_error(string what);
        error_count++;
        if (error_count <= MAX_REPORTS) $display("[%0t] %s", $time, what);
    endtask

    // ------------------------------------------------------------------
    // Input side: one beat per call. valid is left high after acceptance so
    // back-to-back beats stream; only an idle gap or a drain lowers it.
    // ------------------------------------------------------------------
    task automatic send_sample(input logic [SampleW-1:0] s, input logic [TimeW-1:0] t);
        if ($urandom_range(99, 0) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(2, 1)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        key_sample <= s;
        now_ms     <= t;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        pending_results.push_back(predict_mode_step(s, t));
        items_sent++;
    endtask

    task automatic send_key(input key_t k, input int max_step);
        clock_ms += $urandom_range(max_step, 0);
        send_sample(sample_for(k), clock_ms);
    endtask

    // Sender stops and waits for every outstanding result, then lets the pipe settle.
    task automatic wait_results_done();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
        repeat (RESULT_SLACK) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Config side. Only called with the pipe empty.
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [IndexW-1:0] idx, input logic [DataW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            REG_UP_LEVEL:    ladder_cfg.up_level     = data[SampleW-1:0];
            REG_DOWN_LEVEL:  ladder_cfg.down_level   = data[SampleW-1:0];
            REG_PRESS_LEVEL: ladder_cfg.press_level  = data[SampleW-1:0];
            REG_WINDOW_HALF: ladder_cfg.window_half  = data[SampleW-1:0];
            REG_HOLD_TIME:   ladder_cfg.hold_time_ms = data[HoldW-1:0];
            default: ;  // unmapped index, dropped
        endcase
    endtask

    task automatic apply_settings(input int up, input int down, input int press,
                                  input int half, input int hold);
        write_reg(REG_UP_LEVEL, DataW'(up));
        write_reg(REG_DOWN_LEVEL, DataW'(down));
        write_reg(REG_PRESS_LEVEL, DataW'(press));
        write_reg(REG_WINDOW_HALF, DataW'(half));
        // unmapped indexes with junk data must not disturb anything
        for (int i = REG_HOLD_TIME + 1; i < 2 ** IndexW; i++)
            write_reg(IndexW'(i), DataW'($urandom_range(65535, 0)));
        write_reg(REG_HOLD_TIME, DataW'(hold));
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Random traffic, mostly shaped as real switch gestures:
    // long presses that start/stop the block, up/down flicks with held
    // repeats and releases, plus raw noise.
    // ------------------------------------------------------------------
    task automatic run_switch_traffic(input int n_items);
        int   target;
        int   pick;
        int   hold_step;
        key_t k;
        target = items_sent + n_items;
        while (items_sent < target)
        begin
            pick = $urandom_range(99, 0);
            if (pick < 35)
            begin
                hold_step = int'(ladder_cfg.hold_time_ms) * 2 / 3 + 2;
                if ($urandom_range(1, 0)) send_key(KEY_IDLE, 40);
                repeat ($urandom_range(6, 2))
                begin
                    if ($urandom_range(9, 0) == 0) clock_ms += $urandom;
                    send_key(KEY_PRESS, hold_step);
                end
            end
            else if (pick < 70)
            begin
                send_key(KEY_IDLE, 40);
                k = $urandom_range(1, 0) ? KEY_UP : KEY_DN;
                repeat ($urandom_range(3, 1)) send_key(k, 40);
                // other direction without release: ignored as a held repeat
                if ($urandom_range(3, 0) == 0) send_key(k == KEY_UP ? KEY_DN : KEY_UP, 40);
            end
            else if (pick < 85)
            begin
                repeat ($urandom_range(4, 1))
                begin
                    clock_ms += $urandom_range(3000, 0);
                    send_sample(SampleW'($urandom_range(1023, 0)), clock_ms);
                end
            end
            else
            begin
                repeat ($urandom_range(4, 1)) send_key(key_t'($urandom_range(3, 0)), 200);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset config: press 729, down 651, up 1021, half 50, hold 1000.
    task automatic test_directed_keys();
        send_sample(10'd0, 32'd1000);              // floor sample, no key
        send_sample(10'd1023, 32'd1000);           // up window runs past full scale
        send_sample(10'd1023, 32'd1001);           // held up, ignored
        send_sample(10'd779, 32'd1002);            // on the press bound, so no key
        send_sample(10'd680, 32'd1003);            // 680 is in press and down windows: press, timing starts
        send_sample(10'd730, 32'd1004);            // press again, elapsed still 1
        send_sample(10'd730, 32'd1004);            // same stamp, elapsed stays 1
        send_sample(10'd729, 32'd1009);
        send_sample(10'd729, 32'd1010);            // elapsed 7
        send_sample(10'd729, 32'd2010);            // elapsed 1007
        send_sample(10'd729, 32'd2011);            // hold fires: start into sensor
        send_sample(10'd729, 32'd2012);
        send_sample(10'd729, 32'd2014);            // sensor, elapsed 1: calibrate
        send_sample(10'd500, 32'd2020);
        send_sample(10'd1000, 32'd2030);           // up -> position
        send_sample(10'd1000, 32'd2031);           // held up
        send_sample(10'd651, 32'd2032);            // down while up held, ignored
        send_sample(10'd0, 32'd2040);
        send_sample(10'd651, 32'd2050);            // down -> sensor
        send_sample(10'd0, 32'd2060);
        send_sample(10'd651, 32'd2070);            // down -> climate
        send_sample(10'd778, 32'hFFFF_FFF0);       // press near timestamp wrap
        send_sample(10'd700, 32'h0000_0100);       // 700 still press: press wins overlap
        send_sample(10'd729, 32'h0000_0500);
        send_sample(10'd729, 32'h0000_0501);       // hold fires: climate -> stopped
        wait_results_done();
        clock_ms = 32'h0000_1000;
    endtask

    // Corner configurations: empty windows, full-scale windows, windows below
    // zero, zero and maximum hold times.
    task automatic test_config_extremes();
        apply_settings(0, 0, 0, 0, 0);
        run_switch_traffic(40);
        wait_results_done();
        apply_settings(1023, 1023, 1023, 1023, 65535);
        run_switch_traffic(40);
        wait_results_done();
        apply_settings(10, 5, 0, 50, 0);
        run_switch_traffic(40);
        wait_results_done();
        apply_settings(1023, 300, 600, 120, 1);
        run_switch_traffic(40);
        wait_results_done();
    endtask

    // No idle on either side for a long stretch.
    task automatic test_streaming();
        apply_settings(UP_LEVEL_RST, DOWN_LEVEL_RST, PRESS_LEVEL_RST, WINDOW_HALF_RST, 200);
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        run_switch_traffic(150);
        wait_results_done();
        tx_idle_pct  = IDLE_PCT;
        rx_stall_pct = IDLE_PCT;
    endtask

    // Receiver holds off while the sender keeps offering beats, so the pipe
    // fills and in_stall must rise; the drain afterwards is the sender pause.
    task automatic test_backpressure();
        holdoff_cycles = HOLDOFF_LEN;
        tx_idle_pct    = 0;
        run_switch_traffic(30);
        tx_idle_pct    = IDLE_PCT;
        wait_results_done();
    endtask

    // Several random settings, mostly short hold times so holds actually fire.
    task automatic test_random_settings();
        int hold;
        repeat (4)
        begin
            hold = $urandom_range(3, 0) != 0 ? $urandom_range(2000, 0)
                                             : $urandom_range(65535, 0);
            apply_settings($urandom_range(1023, 0), $urandom_range(1023, 0),
                           $urandom_range(1023, 0), $urandom_range(120, 5), hold);
            run_switch_traffic(150);
            wait_results_done();
        end
    endtask

    // ------------------------------------------------------------------
    // Output side: random stall, or a counted hold-off when requested.
    // ------------------------------------------------------------------
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holdoff_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (holdoff_cycles) @(posedge clk);
                holdoff_cycles = 0;
                out_stall <= 1'b0;
            end
            else
            begin
                out_stall <= ($urandom_range(99, 0) < rx_stall_pct);
            end
        end
    end

    // Every accepted result beat is matched against the oldest prediction.
    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.mode          = mode_t'(mode);
            got.key_code      = key_t'(key_code);
            got.clear_display = clear_display;
            got.calibrate     = calibrate;
            if (pending_results.size() == 0)
            begin
                report_error($sformatf("unexpected result beat: mode %0d key %0d clr %b cal %b",
                             got.mode, got.key_code, got.clear_display, got.calibrate));
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.mode !== want.mode || got.key_code !== want.key_code ||
                    got.clear_display !== want.clear_display ||
                    got.calibrate !== want.calibrate)
                    report_error({
                        $sformatf("mismatch: want mode %0d key %0d clr %b cal %b, ",
                                  want.mode, want.key_code, want.clear_display,
                                  want.calibrate),
                        $sformatf("got mode %0d key %0d clr %b cal %b",
                                  got.mode, got.key_code, got.clear_display,
                                  got.calibrate)});
            end
        end
    end

    // Hang detector: any accepted beat on any channel resets the count.
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        key_sample <= '0;
        now_ms     <= '0;
        cfg_valid  <= 1'b0;
        cfg_index  <= '0;
        cfg_data   <= '0;
        ladder_cfg   = '{UP_LEVEL_RST, DOWN_LEVEL_RST, PRESS_LEVEL_RST,
                         WINDOW_HALF_RST, HOLD_TIME_RST};
        cur_mode     = MODE_STOPPED;
        last_key     = KEY_IDLE;
        hold_elapsed = '0;
        hold_begin   = '0;
        clock_ms     = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_keys();
        test_config_extremes();
        test_streaming();
        test_backpressure();
        test_random_settings();

        wait_results_done();
        if (error_count == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- ladder_key_mode_controller.f -----
hdl/lkmc_pkg.sv
hdl/lkmc_key_decode.sv
hdl/lkmc_mode_core.sv
hdl/ladder_key_mode_controller.sv
tb/tb_top.sv
